>>> rtl/tsam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile source address map package
// Shared widths, register indexes, payload types and arithmetic helpers.
// ----------------------------------------------------------------------------
package tsam_pkg;

   localparam int MAX_DIM_DEF = 4096;
   localparam int CRD_W       = 12;
   localparam int DIM_W       = 13;
   localparam int ADDR_W      = 24;
   localparam int IDX_W       = 2;
   localparam int DIV_STEPS   = CRD_W;
   localparam int CFG_STEPS   = DIM_W;
   localparam int CNT_W       = 4;

   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] REG_TILE_FACTOR  = 2'd2;

   // One coordinate in flight through the remainder pipeline.
   typedef struct packed {
      logic [CRD_W-1:0] dvd;
      logic [DIM_W-1:0] dvs;
      logic [DIM_W-1:0] rem;
   } div_type;

   typedef struct packed {
      logic    oor;
      div_type row;
      div_type col;
   } entry_type;

   typedef struct packed {
      logic             busy;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] factor;
      logic [DIM_W-1:0] tile_w;
      logic [DIM_W-1:0] tile_h;
      logic [DIM_W-1:0] switch_x;
      logic [DIM_W-1:0] switch_y;
   } cfg_type;

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int max_dim);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > max_dim) begin
         r = DIM_W'(max_dim);
      end
      return r;
   endfunction

   // One restoring remainder step: brings in the next dividend bit.
   function automatic div_type div_step(div_type s);
      div_type          r;
      logic [DIM_W:0]   trial;
      r     = s;
      trial = {s.rem, s.dvd[CRD_W-1]};
      if (trial >= {1'b0, s.dvs}) begin
         trial = trial - {1'b0, s.dvs};
      end
      r.rem = trial[DIM_W-1:0];
      r.dvd = {s.dvd[CRD_W-2:0], 1'b0};
      return r;
   endfunction

endpackage

>>> rtl/tsam_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile source address map channels
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface tsam_req_if import tsam_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CRD_W-1:0] out_row;
   logic [CRD_W-1:0] out_col;
   modport source (output valid, out_row, out_col, input ready);
   modport sink   (input valid, out_row, out_col, output ready);
endinterface

interface tsam_rsp_if import tsam_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CRD_W-1:0]  src_row;
   logic [CRD_W-1:0]  src_col;
   logic [ADDR_W-1:0] src_addr;
   logic              out_of_range;
   modport source (output valid, src_row, src_col, src_addr, out_of_range, input ready);
   modport sink   (input valid, src_row, src_col, src_addr, out_of_range, output ready);
endinterface

interface tsam_csr_if import tsam_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [DIM_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tile_source_address_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile source address map core
// Maps an output pixel coordinate to its source pixel and linear address.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   req_ch   in         out_row, out_col of one output pixel
//   rsp_ch   out        src_row, src_col, src_addr, out_of_range
//   csr_ch   in         index and data of one register write
//
// One request is accepted per clock unless a write or a stall holds it off;
// each result passes one queue entry, an input stage, twelve remainder
// stages, one scaling multiply and one address multiply-add into the output
// register. A register write derives the tile sizes and switch points with
// a one-bit-per-cycle divider; requests and writes are held off meanwhile.
// Reset clears all registers to one and the derived state to its reset values.
// A stalled response freezes the back end; the two-entry queue lets the front
// end keep taking requests until it fills.
// ----------------------------------------------------------------------------
module tile_source_address_map_core import tsam_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tsam_req_if.sink    req_ch,
   tsam_rsp_if.source  rsp_ch,
   tsam_csr_if.sink    csr_ch
);

   cfg_type   cfg;
   logic      fq_valid, fq_ready, bq_valid, bq_pop;
   entry_type fq_data, bq_data;

   // Register file and derivation of the tile geometry.
   tsam_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Range check and selection of the tile each coordinate falls in.
   tsam_front u_front (
      .req_ch  (req_ch),
      .cfg     (cfg),
      .q_ready (fq_ready),
      .q_valid (fq_valid),
      .q_data  (fq_data)
   );

   tsam_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  (fq_data),
      .rd_valid (bq_valid),
      .rd_pop   (bq_pop),
      .rd_data  (bq_data)
   );

   // Offset within the tile, scale by the factor and form the address.
   tsam_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (bq_valid),
      .q_data  (bq_data),
      .q_pop   (bq_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

>>> rtl/tsam_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile source address map configuration
// Register file and sequential derivation of tile sizes and switch points.
// ----------------------------------------------------------------------------
module tsam_cfg import tsam_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tsam_csr_if.sink    csr_ch,
   output cfg_type     cfg
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_MUL  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIM_W-1:0] raw_w_ff, raw_w_in, raw_h_ff, raw_h_in, raw_n_ff, raw_n_in;
   logic [DIM_W-1:0] w_ff, w_in, h_ff, h_in, n_ff, n_in;
   logic [DIM_W-1:0] dw_ff, dw_in, dh_ff, dh_in;
   logic [DIM_W-1:0] qw_ff, qw_in, qh_ff, qh_in;
   logic [DIM_W-1:0] rw_ff, rw_in, rh_ff, rh_in;
   logic [DIM_W-1:0] tw_ff, tw_in, th_ff, th_in, sx_ff, sx_in, sy_ff, sy_in;
   logic [DIM_W:0]   trial_w, trial_h;
   logic [2*DIM_W:0] prod_x, prod_y;

   assign csr_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      raw_w_in = raw_w_ff;
      raw_h_in = raw_h_ff;
      raw_n_in = raw_n_ff;
      w_in  = w_ff;  h_in  = h_ff;  n_in  = n_ff;
      dw_in = dw_ff; dh_in = dh_ff;
      qw_in = qw_ff; qh_in = qh_ff;
      rw_in = rw_ff; rh_in = rh_ff;
      tw_in = tw_ff; th_in = th_ff;
      sx_in = sx_ff; sy_in = sy_ff;
      trial_w = {rw_ff, dw_ff[DIM_W-1]};
      trial_h = {rh_ff, dh_ff[DIM_W-1]};
      prod_x  = rw_ff * ({1'b0, qw_ff} + (DIM_W+1)'(1));
      prod_y  = rh_ff * ({1'b0, qh_ff} + (DIM_W+1)'(1));
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_ch.valid) begin
               case (csr_ch.index)
                  REG_IMAGE_WIDTH: begin
                     raw_w_in = csr_ch.data;
                     state_in = ST_LOAD;
                  end
                  REG_IMAGE_HEIGHT: begin
                     raw_h_in = csr_ch.data;
                     state_in = ST_LOAD;
                  end
                  REG_TILE_FACTOR: begin
                     raw_n_in = csr_ch.data;
                     state_in = ST_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            w_in  = clamp_dim(raw_w_ff, MAX_DIM);
            h_in  = clamp_dim(raw_h_ff, MAX_DIM);
            n_in  = clamp_dim(raw_n_ff, MAX_DIM);
            dw_in = w_in;
            dh_in = h_in;
            rw_in = '0;
            rh_in = '0;
            qw_in = '0;
            qh_in = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial_w >= {1'b0, n_ff}) begin
               trial_w = trial_w - {1'b0, n_ff};
               qw_in   = {qw_ff[DIM_W-2:0], 1'b1};
            end else begin
               qw_in   = {qw_ff[DIM_W-2:0], 1'b0};
            end
            if (trial_h >= {1'b0, n_ff}) begin
               trial_h = trial_h - {1'b0, n_ff};
               qh_in   = {qh_ff[DIM_W-2:0], 1'b1};
            end else begin
               qh_in   = {qh_ff[DIM_W-2:0], 1'b0};
            end
            rw_in  = trial_w[DIM_W-1:0];
            rh_in  = trial_h[DIM_W-1:0];
            dw_in  = {dw_ff[DIM_W-2:0], 1'b0};
            dh_in  = {dh_ff[DIM_W-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CFG_STEPS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // The switch point never exceeds the image size, so it fits.
            tw_in = qw_ff;
            th_in = qh_ff;
            sx_in = prod_x[DIM_W-1:0];
            sy_in = prod_y[DIM_W-1:0];
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         raw_w_ff <= DIM_W'(1);
         raw_h_ff <= DIM_W'(1);
         raw_n_ff <= DIM_W'(1);
         w_ff  <= DIM_W'(1);
         h_ff  <= DIM_W'(1);
         n_ff  <= DIM_W'(1);
         tw_ff <= DIM_W'(1);
         th_ff <= DIM_W'(1);
         sx_ff <= '0;
         sy_ff <= '0;
      end else begin
         state_ff <= state_in;
         raw_w_ff <= raw_w_in;
         raw_h_ff <= raw_h_in;
         raw_n_ff <= raw_n_in;
         w_ff  <= w_in;
         h_ff  <= h_in;
         n_ff  <= n_in;
         tw_ff <= tw_in;
         th_ff <= th_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
      cnt_ff <= cnt_in;
      dw_ff  <= dw_in;
      dh_ff  <= dh_in;
      qw_ff  <= qw_in;
      qh_ff  <= qh_in;
      rw_ff  <= rw_in;
      rh_ff  <= rh_in;
   end

   assign cfg.busy     = (state_ff != ST_IDLE);
   assign cfg.width    = w_ff;
   assign cfg.height   = h_ff;
   assign cfg.factor   = n_ff;
   assign cfg.tile_w   = tw_ff;
   assign cfg.tile_h   = th_ff;
   assign cfg.switch_x = sx_ff;
   assign cfg.switch_y = sy_ff;

endmodule

>>> rtl/tsam_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile source address map front end
// Accepts requests, checks range and picks the dividend and divisor per axis.
// ----------------------------------------------------------------------------
module tsam_front import tsam_pkg::*; (
   tsam_req_if.sink  req_ch,
   input  cfg_type   cfg,
   input  logic      q_ready,
   output logic      q_valid,
   output entry_type q_data
);

   function automatic div_type classify(logic [CRD_W-1:0] c, logic [DIM_W-1:0] sw,
                                        logic [DIM_W-1:0] tile);
      div_type r;
      r.rem = '0;
      if ({1'b0, c} >= sw) begin
         // Narrow tiles past the switch point.
         r.dvd = c - sw[CRD_W-1:0];
         r.dvs = tile;
      end else begin
         r.dvd = c;
         r.dvs = tile + DIM_W'(1);
      end
      // A zero divisor yields a zero offset.
      if (r.dvs == '0) begin
         r.dvd = '0;
      end
      return r;
   endfunction

   assign req_ch.ready = q_ready && !cfg.busy;
   assign q_valid      = req_ch.valid && !cfg.busy;

   always_comb begin
      q_data.oor = ({1'b0, req_ch.out_row} >= cfg.height) ||
                   ({1'b0, req_ch.out_col} >= cfg.width);
      q_data.row = classify(req_ch.out_row, cfg.switch_y, cfg.tile_h);
      q_data.col = classify(req_ch.out_col, cfg.switch_x, cfg.tile_w);
   end

endmodule

>>> rtl/tsam_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile source address map queue
// Two-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tsam_queue import tsam_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   output logic      wr_ready,
   input  entry_type wr_data,
   output logic      rd_valid,
   input  logic      rd_pop,
   output entry_type rd_data
);

   entry_type  mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_pop && rd_valid;
   assign rd_data  = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (pop) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/tsam_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile source address map back end
// Pipelined remainder, scale by the factor, linear address, output register.
// ----------------------------------------------------------------------------
module tsam_back import tsam_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_valid,
   input  entry_type q_data,
   output logic      q_pop,
   tsam_rsp_if.source rsp_ch
);

   entry_type            st_ff [DIV_STEPS+1];
   logic [DIV_STEPS:0]   vld_ff;
   logic                 mv_ff, mo_ff;
   logic [DIM_W-1:0]     sr_ff, sc_ff;
   logic                 ov_ff, oo_ff;
   logic [CRD_W-1:0]     or_ff, oc_ff;
   logic [ADDR_W-1:0]    oa_ff;
   logic                 adv;
   logic [2*DIM_W-1:0]   pr, pc, pa;
   logic [2*DIM_W:0]     addr;

   // The whole pipeline moves whenever the output register can take a result.
   assign adv   = !ov_ff || rsp_ch.ready;
   assign q_pop = adv;

   assign pr   = st_ff[DIV_STEPS].row.rem * cfg.factor;
   assign pc   = st_ff[DIV_STEPS].col.rem * cfg.factor;
   assign pa   = sr_ff * cfg.width;
   assign addr = {1'b0, pa} + {{(DIM_W+1){1'b0}}, sc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         mv_ff  <= 1'b0;
         ov_ff  <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DIV_STEPS-1:0], q_valid};
         mv_ff  <= vld_ff[DIV_STEPS];
         ov_ff  <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= q_data;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            st_ff[k].oor <= st_ff[k-1].oor;
            st_ff[k].row <= div_step(st_ff[k-1].row);
            st_ff[k].col <= div_step(st_ff[k-1].col);
         end
         mo_ff <= st_ff[DIV_STEPS].oor;
         sr_ff <= pr[DIM_W-1:0];
         sc_ff <= pc[DIM_W-1:0];
         oo_ff <= mo_ff;
         if (mo_ff) begin
            or_ff <= '0;
            oc_ff <= '0;
            oa_ff <= '0;
         end else begin
            or_ff <= sr_ff[CRD_W-1:0];
            oc_ff <= sc_ff[CRD_W-1:0];
            oa_ff <= addr[ADDR_W-1:0];
         end
      end
   end

   assign rsp_ch.valid        = ov_ff;
   assign rsp_ch.src_row      = or_ff;
   assign rsp_ch.src_col      = oc_ff;
   assign rsp_ch.src_addr     = oa_ff;
   assign rsp_ch.out_of_range = oo_ff;

endmodule

>>> tb/sv/tb_tsam_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile source address map scoreboard
// Predicts each source pixel from the register settings and checks responses.
// ----------------------------------------------------------------------------
import tsam_pkg::*;

class tsam_scoreboard;

   typedef struct {
      logic [CRD_W-1:0]  src_row;
      logic [CRD_W-1:0]  src_col;
      logic [ADDR_W-1:0] src_addr;
      logic              out_of_range;
   } pixel_type;

   int unsigned width_reg, height_reg, factor_reg;
   int unsigned tile_w, tile_h, switch_x, switch_y;
   pixel_type   pending_pixels[$];
   int unsigned error_count;

   function new();
      width_reg   = 1;
      height_reg  = 1;
      factor_reg  = 1;
      error_count = 0;
      derive_tiles();
   endfunction

   function int unsigned clamp_size(int unsigned v);
      if (v < 1) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
   endfunction

   function void derive_tiles();
      int unsigned w, h, n;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      n = clamp_size(factor_reg);
      tile_w   = w / n;
      tile_h   = h / n;
      switch_x = (w - tile_w * n) * (tile_w + 1);
      switch_y = (h - tile_h * n) * (tile_h + 1);
   endfunction

   function void write_register(logic [IDX_W-1:0] index, logic [DIM_W-1:0] data);
      case (index)
         REG_IMAGE_WIDTH:  width_reg  = data;
         REG_IMAGE_HEIGHT: height_reg = data;
         REG_TILE_FACTOR:  factor_reg = data;
         default: return;
      endcase
      derive_tiles();
   endfunction

   function int unsigned scale_coord(int unsigned c, int unsigned sw, int unsigned tile,
                                     int unsigned n);
      int unsigned off;
      if (c >= sw) off = (tile == 0) ? 0 : (c - sw) % tile;
      else off = c % (tile + 1);
      return off * n;
   endfunction

   // Notes an accepted request and queues the pixel it should produce.
   function void note_request(logic [CRD_W-1:0] row, logic [CRD_W-1:0] col);
      pixel_type   p;
      int unsigned w, h, n, sr, sc;
      longint unsigned addr;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      n = clamp_size(factor_reg);
      if (row >= h || col >= w) begin
         p = '{'0, '0, '0, 1'b1};
      end else begin
         sr   = scale_coord(row, switch_y, tile_h, n);
         sc   = scale_coord(col, switch_x, tile_w, n);
         addr = longint'(sr) * w + sc;
         p    = '{sr[CRD_W-1:0], sc[CRD_W-1:0], addr[ADDR_W-1:0], 1'b0};
      end
      pending_pixels.push_back(p);
   endfunction

   function void check_response(pixel_type got);
      pixel_type e;
      if (pending_pixels.size() == 0) begin
         $display("%0t: unexpected response row=%0d col=%0d addr=%0d oor=%0b", $time,
                  got.src_row, got.src_col, got.src_addr, got.out_of_range);
         error_count++;
         return;
      end
      e = pending_pixels.pop_front();
      if (got.src_row !== e.src_row) begin
         $display("%0t: src_row expected %0d actual %0d", $time, e.src_row, got.src_row);
         error_count++;
      end
      if (got.src_col !== e.src_col) begin
         $display("%0t: src_col expected %0d actual %0d", $time, e.src_col, got.src_col);
         error_count++;
      end
      if (got.src_addr !== e.src_addr) begin
         $display("%0t: src_addr expected %0d actual %0d", $time, e.src_addr, got.src_addr);
         error_count++;
      end
      if (got.out_of_range !== e.out_of_range) begin
         $display("%0t: out_of_range expected %0b actual %0b", $time, e.out_of_range,
                  got.out_of_range);
         error_count++;
      end
   endfunction
endclass

>>> tb/sv/tb_tile_source_address_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile source address map testbench
// Drives pixel requests and register writes, predicts every response.
// ----------------------------------------------------------------------------
module tb_tile_source_address_map_core;
   import tsam_pkg::*;

   // Cycles without any accepted request, response or write before giving up.
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;

   tsam_req_if req_ch ();
   tsam_rsp_if rsp_ch ();
   tsam_csr_if csr_ch ();

   tsam_scoreboard pixel_board;
   int  idle_cycles;

   tile_source_address_map_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Every input starts at a known value.
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.out_row = '0;
      req_ch.out_col = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_IMAGE_WIDTH;
      csr_ch.data    = '0;
   end

   // The watchdog restarts on every handshake of any channel.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver inserts a random stall before each response, and
   // sometimes runs stretches with ready held high.
   initial begin
      int stall;
      int fast_left;
      fast_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (fast_left > 0) begin
            fast_left--;
            stall = 0;
         end else begin
            stall = $urandom_range(0, 10);
            if ($urandom_range(0, 15) == 0) fast_left = $urandom_range(10, 60);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         pixel_board.check_response('{rsp_ch.src_row, rsp_ch.src_col, rsp_ch.src_addr,
                                      rsp_ch.out_of_range});
      end
   end

   // Writes one register while the block is idle; valid stays high for the
   // next write and is dropped by the caller.
   task automatic write_register(logic [IDX_W-1:0] index, logic [DIM_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      pixel_board.write_register(index, data);
   endtask

   // Waits until every predicted response has come back, then lets the block settle.
   task automatic wait_drained();
      while (pixel_board.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned n);
      wait_drained();
      write_register(REG_IMAGE_WIDTH, DIM_W'(w));
      write_register(REG_IMAGE_HEIGHT, DIM_W'(h));
      write_register(REG_TILE_FACTOR, DIM_W'(n));
      csr_ch.valid <= 1'b0;
   endtask

   // Sends one request; gap is the idle time before it. Valid stays high
   // across back-to-back requests.
   task automatic send_request(logic [CRD_W-1:0] row, logic [CRD_W-1:0] col, int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.out_row <= row;
      req_ch.out_col <= col;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pixel_board.note_request(row, col);
   endtask

   task automatic stop_requests();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly in-image coordinates, with some just past the edges and some anywhere.
   function automatic logic [CRD_W-1:0] pick_coord(int unsigned size);
      int unsigned s;
      s = pixel_board.clamp_size(size);
      case ($urandom_range(0, 9))
         0:       return CRD_W'($urandom());
         1:       return CRD_W'(s - 1 + $urandom_range(0, 2));
         2:       return CRD_W'(s - 1);
         default: return CRD_W'($urandom_range(0, s - 1));
      endcase
   endfunction

   function automatic int unsigned pick_size();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 8191);
         1:       return 4096;
         2:       return $urandom_range(1, 4);
         default: return $urandom_range(1, 300);
      endcase
   endfunction

   initial begin
      int unsigned w, h, n;
      int burst;
      pixel_board = new();
      idle_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: a 1 by 1 image, so only the origin is inside.
      send_request(0, 0, 0);
      send_request(0, 1, 0);
      send_request(1, 0, 0);
      send_request(12'hFFF, 12'hFFF, 0);
      stop_requests();

      // Largest image with an uneven factor: both tile widths and the far edges.
      configure(4096, 4096, 3);
      send_request(0, 0, 0);
      send_request(12'hFFF, 12'hFFF, 0);
      send_request(1365, 1366, 1);
      send_request(2730, 2731, 0);
      send_request(12'hAAA, 12'h555, 0);
      send_request(12'h555, 12'hAAA, 2);
      stop_requests();

      // Factor larger than the image: every pixel maps to the origin.
      configure(7, 5, 4096);
      send_request(6, 4, 0);
      send_request(4, 6, 0);
      send_request(5, 7, 0);
      stop_requests();

      // Zero registers act as one; oversized ones clamp to the largest size.
      configure(0, 8191, 0);
      send_request(0, 0, 0);
      send_request(4095, 0, 0);
      send_request(0, 1, 0);
      stop_requests();
      configure(8191, 0, 8191);
      send_request(0, 4095, 0);
      send_request(1, 0, 0);
      stop_requests();

      // Factor of one maps a pixel to itself; the largest address fills the address width.
      configure(4096, 4096, 1);
      send_request(4095, 4095, 0);
      send_request(2048, 17, 0);
      send_request(4095, 0, 0);
      stop_requests();

      // Random phases, each with fresh registers and a burst of requests.
      for (int phase = 0; phase < 40; phase++) begin
         w = pick_size();
         h = pick_size();
         n = ($urandom_range(0, 4) == 0) ? pick_size() : $urandom_range(1, 9);
         configure(w, h, n);
         burst = $urandom_range(20, 45);
         for (int i = 0; i < burst; i++) begin
            send_request(pick_coord(h), pick_coord(w),
                         ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10));
         end
         stop_requests();
         // Hold off until the pipeline is empty once every fifth phase.
         if (phase % 5 == 0) begin
            while (pixel_board.pending_pixels.size() != 0) @(posedge clock);
         end
      end

      wait_drained();
      if (pixel_board.error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
